// File: rtl/core/letter_multiset_compare_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the letter multiset comparator
// Clocked concurrent checks on clk; the reset-qualified form is disabled
// while arst_n is low. Both forms compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LETTER_MULTISET_COMPARE_ASSERT_SVH
`define LETTER_MULTISET_COMPARE_ASSERT_SVH

`ifndef SYNTH
// Check held outside of reset.
`define LMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check held at every edge, during reset too.
`define LMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMC_ASSERT(lbl, prop, msg)
`define LMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared constants and types of the letter multiset comparator.
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int COUNT_BITS    = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [7:0] CASE_FOLD = 8'h20;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_Z    = 8'h5A;

	typedef logic [ALPHABET_SIZE-1:0]                 letter_sel_t;
	typedef logic [ALPHABET_SIZE-1:0][COUNT_BITS-1:0] count_vec_t;

	typedef enum logic [1:0] {
		MODE_WITHIN    = 2'd0,
		MODE_CONTAINS  = 2'd1,
		MODE_EQUAL     = 2'd2,
		MODE_NOT_EQUAL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_QUERY = 2'd1,
		ERR_WORD  = 2'd2
	} err_t;

	// Per-word control of one count bank.
	typedef struct packed {
		logic        upd;        // a word for this bank is accepted
		logic        clear_pre;  // start from zero counts
		logic        add;        // count the selected letter if not saturated
		logic        clear_post; // store zero counts afterwards
		letter_sel_t sel;        // one-hot letter lane
	} bank_ctl_t;

endpackage

// File: rtl/core/lmc_letter_decode.sv
// ----------------------------------------------------------------------------
// lmc_letter_decode
// Folds case and turns a character byte into a one-hot letter lane.
// ----------------------------------------------------------------------------
module lmc_letter_decode (
	input  logic [7:0]          char_code,
	output logic                letter_ok,
	output lmc_pkg::letter_sel_t sel
);
	import lmc_pkg::*;

	logic [7:0] up;
	logic [7:0] diff;

	assign up   = char_code & ~CASE_FOLD;
	assign diff = up - CHAR_A;

	assign letter_ok = (up >= CHAR_A) && (up <= CHAR_Z)
		&& (diff < 8'(ALPHABET_SIZE));

	always_comb begin
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			sel[i] = letter_ok && (diff == 8'(i));
		end
	end

endmodule

// File: rtl/core/lmc_count_bank.sv
// ----------------------------------------------------------------------------
// lmc_count_bank
// One row of saturation-checked letter counters, one lane per letter.
// ----------------------------------------------------------------------------
module lmc_count_bank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lmc_pkg::bank_ctl_t   ctl,
	output lmc_pkg::count_vec_t  counts_q,
	output lmc_pkg::count_vec_t  sum,
	output logic                 full
);
	import lmc_pkg::*;

	count_vec_t base;
	logic       inc_ok;

	assign base = ctl.clear_pre ? '0 : counts_q;

	// selected lane already at its maximum
	always_comb begin
		full = 1'b0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			full = full | (ctl.sel[i] && (base[i] == COUNT_MAX));
		end
	end

	assign inc_ok = ctl.add && !full;

	always_comb begin
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			sum[i] = base[i] + COUNT_BITS'(inc_ok && ctl.sel[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (ctl.upd) begin
			counts_q <= ctl.clear_post ? '0 : sum;
		end
	end

endmodule

// File: rtl/core/lmc_compare.sv
// ----------------------------------------------------------------------------
// lmc_compare
// Lane-wise multiset relations between word and query counts.
// ----------------------------------------------------------------------------
module lmc_compare (
	input  lmc_pkg::mode_t      mode,
	input  lmc_pkg::count_vec_t query,
	input  lmc_pkg::count_vec_t word,
	output logic                hit
);
	import lmc_pkg::*;

	logic fits;
	logic contains;
	logic equal;

	always_comb begin
		fits     = 1'b1;
		contains = 1'b1;
		equal    = 1'b1;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			fits     = fits     & (word[i] <= query[i]);
			contains = contains & (query[i] <= word[i]);
			equal    = equal    & (word[i] == query[i]);
		end
	end

	always_comb begin
		case (mode)
			MODE_WITHIN:    hit = fits;
			MODE_CONTAINS:  hit = contains;
			MODE_EQUAL:     hit = equal;
			MODE_NOT_EQUAL: hit = !equal;
			default:        hit = 1'b0;
		endcase
	end

endmodule

// File: rtl/core/letter_multiset_compare.sv
// ----------------------------------------------------------------------------
// letter_multiset_compare
// Query and word letter counting with a multiset compare at each word end.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, both strings alike, while s_tready is high.
// Result: a word's final letter, once accepted, is captured in the result register
//   (one register) and driven onto m_* from there.
// s_tready stays high while a result waits, as long as m_tready takes it.
// Reset (arst_n low, asynchronous): all counts zero, query marked finished,
//   no invalid flags, compare_mode 0, no result pending.
// ----------------------------------------------------------------------------
`include "letter_multiset_compare_assert.svh"

module letter_multiset_compare (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: compare_mode
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	// character words
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] command: 0 query, 1 word
	input  logic       s_tlast,   // last character of the string
	// result words
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] match, [2:1] error_code, [7:3] zero
);
	import lmc_pkg::*;

	// ---------------------------------------------------------------- state
	mode_t mode_q;
	logic  query_finished_q;
	logic  query_invalid_q;
	logic  word_invalid_q;

	logic  out_valid_q;
	logic  match_q;
	err_t  err_q;

	// ---------------------------------------------------------- handshakes
	logic acc;
	logic q_step;
	logic w_step;
	logic w_end;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign q_step    = acc && !s_tuser;
	assign w_step    = acc && s_tuser;
	assign w_end     = w_step && s_tlast;

	// ------------------------------------------------------ letter decode
	logic        letter_ok;
	letter_sel_t sel;

	lmc_letter_decode u_decode (
		.char_code (s_tdata),
		.letter_ok (letter_ok),
		.sel       (sel)
	);

	// -------------------------------------------------------- query bank
	// A query letter after a finished query starts a fresh query.
	logic       q_inv_base;
	bank_ctl_t  q_ctl;
	count_vec_t q_counts;
	count_vec_t q_sum;
	logic       q_full;

	assign q_inv_base = query_finished_q ? 1'b0 : query_invalid_q;

	assign q_ctl.upd        = q_step;
	assign q_ctl.clear_pre  = query_finished_q;
	assign q_ctl.add        = letter_ok && !q_inv_base;
	assign q_ctl.clear_post = 1'b0;
	assign q_ctl.sel        = sel;

	lmc_count_bank u_query (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (q_ctl),
		.counts_q (q_counts),
		.sum      (q_sum),
		.full     (q_full)
	);

	// --------------------------------------------------------- word bank
	// Word counts clear as the final letter is taken.
	bank_ctl_t  w_ctl;
	count_vec_t w_counts;
	count_vec_t w_sum;
	logic       w_full;
	logic       w_inv_next;

	assign w_ctl.upd        = w_step;
	assign w_ctl.clear_pre  = 1'b0;
	assign w_ctl.add        = letter_ok && !word_invalid_q;
	assign w_ctl.clear_post = s_tlast;
	assign w_ctl.sel        = sel;

	lmc_count_bank u_word (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (w_ctl),
		.counts_q (w_counts),
		.sum      (w_sum),
		.full     (w_full)
	);

	assign w_inv_next = word_invalid_q || !letter_ok || w_full;

	// ------------------------------------------------------------ compare
	// Word counts include this letter; query counts as they stand.
	logic hit;

	lmc_compare u_compare (
		.mode  (mode_q),
		.query (q_counts),
		.word  (w_sum),
		.hit   (hit)
	);

	// ---------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_WITHIN;
			query_finished_q <= 1'b1;
			query_invalid_q  <= 1'b0;
			word_invalid_q   <= 1'b0;
			out_valid_q      <= 1'b0;
			match_q          <= 1'b0;
			err_q            <= ERR_NONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= mode_t'(cfg_data);
			end
			if (q_step) begin
				query_invalid_q  <= q_inv_base || !letter_ok || q_full;
				query_finished_q <= s_tlast;
			end
			if (w_step) begin
				word_invalid_q <= s_tlast ? 1'b0 : w_inv_next;
			end
			if (w_end) begin
				out_valid_q <= 1'b1;
				// query error wins over word error
				if (query_invalid_q) begin
					match_q <= 1'b0;
					err_q   <= ERR_QUERY;
				end else if (w_inv_next) begin
					match_q <= 1'b0;
					err_q   <= ERR_WORD;
				end else begin
					match_q <= hit;
					err_q   <= ERR_NONE;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, err_q, match_q};

	// --------------------------------------------------------- assertions
	`LMC_ASSERT(a_match_only_ok, out_valid_q && match_q |-> err_q == ERR_NONE, "match with error")
	`LMC_ASSERT(a_result_from_word_end, $rose(out_valid_q) |-> $past(w_end), "stray result")
	`LMC_ASSERT(a_word_cleared, w_end |=> (w_counts == '0) && !word_invalid_q, "word not cleared")
	`LMC_ASSERT(a_query_closes, q_step && s_tlast |=> query_finished_q, "query not finished")
	`LMC_ASSERT(a_query_stored, q_step |=> q_counts == $past(q_sum), "query counts not stored")
	`LMC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid_q, "result during reset")

endmodule
